// ----- hw/rtl/cylinder_mesh_generator_top_assert.svh -----
// Assertion macros for the cylinder mesh generator.
// Used by cylinder_mesh_generator_top; no other dependencies.
`ifndef CYLINDER_MESH_GENERATOR_TOP_ASSERT_SVH
`define CYLINDER_MESH_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CMG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define CMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cmg_pkg.sv -----
// Package for the cylinder mesh generator: field widths, register indexes,
// sequencer states, CORDIC constants and helper functions. No dependencies.
`default_nettype none

package cmg_pkg;

	localparam int SLICE_W  = 9;
	localparam int IDX_W    = 10;
	localparam int POS_W    = 17;
	localparam int HALF_W   = 16;
	localparam int NORM_W   = 16;
	localparam int REG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int XY_W     = 34;
	localparam int ATAN_LEN = 24;

	localparam int DEF_MAX_SLICES   = 256;
	localparam int DEF_CORDIC_STEPS = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICES     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 2'd3;

	localparam logic [15:0] RST_RADIUS     = 16'd256;
	localparam logic [15:0] RST_LENGTH     = 16'd512;
	localparam logic [8:0]  RST_SLICES     = 9'd30;
	localparam logic [15:0] RST_ANGLE_STEP = 16'd2185;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TRI    = 1'b1;

	// pi/2 in Q2.30 and the CORDIC gain compensation in Q2.30
	localparam logic [30:0]            HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PHASE,
		ST_ZMUL,
		ST_ROT,
		ST_ROUND,
		ST_MULX,
		ST_MULZ,
		ST_EMIT
	} cmg_state_t;

	function automatic logic signed [XY_W-1:0] atan_q30(input logic [4:0] idx);
		logic signed [XY_W-1:0] v;
		case (idx)
			5'd0:  v = 34'sh3243F6A8;
			5'd1:  v = 34'sh1DAC6705;
			5'd2:  v = 34'sh0FADBAFC;
			5'd3:  v = 34'sh07F56EA6;
			5'd4:  v = 34'sh03FEAB76;
			5'd5:  v = 34'sh01FFD55B;
			5'd6:  v = 34'sh00FFFAAA;
			5'd7:  v = 34'sh007FFF55;
			5'd8:  v = 34'sh003FFFEA;
			5'd9:  v = 34'sh001FFFFD;
			5'd10: v = 34'sh000FFFFF;
			5'd11: v = 34'sh0007FFFF;
			5'd12: v = 34'sh0003FFFF;
			5'd13: v = 34'sh0001FFFF;
			5'd14: v = 34'sh0000FFFF;
			5'd15: v = 34'sh00007FFF;
			5'd16: v = 34'sh00003FFF;
			5'd17: v = 34'sh00001FFF;
			5'd18: v = 34'sh00000FFF;
			5'd19: v = 34'sh000007FF;
			5'd20: v = 34'sh000003FF;
			5'd21: v = 34'sh000001FF;
			5'd22: v = 34'sh000000FF;
			5'd23: v = 34'sh0000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Q2.30 to Q1.14 with round half up, clamped to +-1.0
	function automatic logic signed [NORM_W-1:0] round_q14(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] r;
		logic signed [NORM_W-1:0] o;
		r = (v + 34'sd32768) >>> 16;
		if (r > 34'sd16384) begin
			o = 16'sd16384;
		end else if (r < -34'sd16384) begin
			o = -16'sd16384;
		end else begin
			o = r[NORM_W-1:0];
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cmg_in_if.sv -----
// Slice input channel: valid/ready handshake with the slice number.
// Depends on cmg_pkg for the field width.
`default_nettype none

interface cmg_in_if;
	import cmg_pkg::*;

	logic               valid;
	logic               ready;
	logic [SLICE_W-1:0] slice;

	modport source (output valid, output slice, input ready);
	modport sink   (input valid, input slice, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cmg_out_if.sv -----
// Result channel: valid/ready handshake with one vertex or triangle.
// Depends on cmg_pkg for the field widths.
`default_nettype none

interface cmg_out_if;
	import cmg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [HALF_W-1:0] pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic signed [NORM_W-1:0] norm_x;
	logic signed [NORM_W-1:0] norm_z;
	logic [IDX_W-1:0]         vertex_number;
	logic [IDX_W-1:0]         tri_a;
	logic [IDX_W-1:0]         tri_b;
	logic [IDX_W-1:0]         tri_c;
	logic                     last;

	modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_z, output vertex_number, output tri_a, output tri_b,
		output tri_c, output last, input ready);
	modport sink (input valid, input kind, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_z, input vertex_number, input tri_a, input tri_b,
		input tri_c, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cylinder_mesh_generator_top.sv -----
// Cylinder side-mesh generator: slice number in, vertices and triangles out.
// Depends on cmg_pkg, cmg_in_if, cmg_out_if and the assertion header.
//
// Usage:
//   slice_ch   one transaction per slice number (0 up to and including slices).
//   result_ch  per slice: top vertex, bottom vertex, then for slice < slices the
//              two triangles; last marks the final result of the slice.
//   cfg_*      register writes (radius, length, slices, angle_step), taken on
//              any rising edge with cfg_we high; write only while the block is idle.
// Sequence: one slice at a time. After acceptance the sequencer runs the phase
// multiply, the radian multiply, CORDIC_STEPS iterations of the shared shift-add
// CORDIC unit, rounding, then the radius multiplier (shared for x and z), first
// for x and then for z, and finally hands out the results from its emit step.
// A slice above the slice count is dropped and the block is ready again next
// cycle. slice_ch.ready is high whenever the sequencer is idle, also while the
// final result still sits in the output register.
// A receiver stall holds the output register; the sequencer waits in its emit
// step. Reset returns registers to defaults and clears all valid state.
`default_nettype none
`include "cylinder_mesh_generator_top_assert.svh"

module cylinder_mesh_generator_top #(
	parameter int MAX_SLICES   = cmg_pkg::DEF_MAX_SLICES,
	parameter int CORDIC_STEPS = cmg_pkg::DEF_CORDIC_STEPS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	cmg_in_if.sink                              slice_ch,
	cmg_out_if.source                           result_ch,
	input  wire logic                           cfg_we,
	input  wire logic [cmg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cmg_pkg::REG_W-1:0]      cfg_data
);
	import cmg_pkg::*;

	localparam int ITW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// configuration
	logic [15:0]        radius_q;
	logic [15:0]        length_q;
	logic [SLICE_W-1:0] slices_q;
	logic [15:0]        angle_step_q;

	// sequencer and datapath
	cmg_state_t             state_q, state_d;
	logic [SLICE_W-1:0]     slice_q;
	logic                   many_q;
	logic [15:0]            phase_q;
	logic signed [XY_W-1:0] x_q, y_q, z_q;
	logic [ITW-1:0]         it_q;
	logic signed [NORM_W-1:0] c_q, s_q;
	logic signed [POS_W-1:0]  px_q, pz_q;
	logic [1:0]             k_q;

	// output register
	logic                     out_valid_q;
	logic                     kind_q;
	logic signed [POS_W-1:0]  opx_q, opz_q;
	logic signed [HALF_W-1:0] opy_q;
	logic signed [NORM_W-1:0] onx_q, onz_q;
	logic [IDX_W-1:0]         ovn_q, ota_q, otb_q, otc_q;
	logic                     olast_q;

	logic [SLICE_W-1:0] count;
	logic               accept;
	logic               skip;
	logic               emit_load;
	logic               emit_last;
	logic               rot_done;

	logic [24:0]              phase_prod;
	logic [44:0]              z_prod;
	logic signed [XY_W-1:0]   dx, dy, at;
	logic signed [NORM_W-1:0] c_rnd, s_rnd;
	logic signed [NORM_W-1:0] mul_b;
	logic signed [32:0]       mul_p;
	logic signed [33:0]       mul_r;
	logic [IDX_W-1:0]         base;
	logic signed [HALF_W-1:0] half;

	logic rot_ok;
	logic norm_ok;
	logic emit_stall;

	assign count  = (int'(slices_q) > MAX_SLICES) ? SLICE_W'(MAX_SLICES) : slices_q;
	assign accept = slice_ch.valid && slice_ch.ready;
	assign skip   = slice_ch.slice > count;
	assign rot_done = (it_q == ITW'(CORDIC_STEPS - 1));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= RST_RADIUS;
			length_q     <= RST_LENGTH;
			slices_q     <= RST_SLICES;
			angle_step_q <= RST_ANGLE_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:     radius_q     <= cfg_data;
				REG_LENGTH:     length_q     <= cfg_data;
				REG_SLICES:     slices_q     <= cfg_data[SLICE_W-1:0];
				REG_ANGLE_STEP: angle_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && !skip) state_d = ST_PHASE;
			ST_PHASE: state_d = ST_ZMUL;
			ST_ZMUL:  state_d = ST_ROT;
			ST_ROT:   if (rot_done) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_MULX;
			ST_MULX:  state_d = ST_MULZ;
			ST_MULZ:  state_d = ST_EMIT;
			ST_EMIT:  if (emit_load && emit_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		slice_ch.ready = (state_q == ST_IDLE);
		emit_load      = (state_q == ST_EMIT) && (!out_valid_q || result_ch.ready);
		emit_last      = (k_q == 2'd3) || ((k_q == 2'd1) && !many_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath arithmetic
	assign phase_prod = 25'(slice_q) * 25'(angle_step_q);
	assign z_prod     = 45'(phase_q[13:0]) * 45'(HALF_PI_Q30);

	// shared CORDIC shift-add unit
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign at = atan_q30(5'(it_q));

	assign c_rnd = round_q14(x_q);
	assign s_rnd = round_q14(y_q);

	// radius multiplier, shared between x and z
	assign mul_b = (state_q == ST_MULX) ? c_q : s_q;
	assign mul_p = 33'($signed({1'b0, radius_q})) * 33'(mul_b);
	assign mul_r = (34'(mul_p) + 34'sd8192) >>> 14;

	assign base = {slice_q, 1'b0};
	assign half = $signed({1'b0, length_q[15:1]});

	always_ff @(posedge clk) begin
		if (accept) begin
			slice_q <= slice_ch.slice;
			many_q  <= slice_ch.slice < count;
		end
		case (state_q)
			ST_PHASE: phase_q <= phase_prod[15:0];
			ST_ZMUL: begin
				z_q  <= $signed({3'b000, z_prod[44:14]});
				x_q  <= GAIN_Q30;
				y_q  <= '0;
				it_q <= '0;
			end
			ST_ROT: begin
				if (!z_q[XY_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				it_q <= it_q + ITW'(1);
			end
			ST_ROUND: begin
				case (phase_q[15:14])
					2'd0: begin c_q <= c_rnd;  s_q <= s_rnd;  end
					2'd1: begin c_q <= -s_rnd; s_q <= c_rnd;  end
					2'd2: begin c_q <= -c_rnd; s_q <= -s_rnd; end
					default: begin c_q <= s_rnd; s_q <= -c_rnd; end
				endcase
				k_q <= 2'd0;
			end
			ST_MULX: px_q <= mul_r[POS_W-1:0];
			ST_MULZ: pz_q <= mul_r[POS_W-1:0];
			ST_EMIT: if (emit_load) k_q <= k_q + 2'd1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			olast_q <= emit_last;
			if (!k_q[1]) begin
				kind_q <= KIND_VERTEX;
				opx_q  <= px_q;
				opy_q  <= k_q[0] ? -half : half;
				opz_q  <= pz_q;
				onx_q  <= c_q;
				onz_q  <= s_q;
				ovn_q  <= base + IDX_W'(k_q[0]);
				ota_q  <= '0;
				otb_q  <= '0;
				otc_q  <= '0;
			end else begin
				kind_q <= KIND_TRI;
				opx_q  <= '0;
				opy_q  <= '0;
				opz_q  <= '0;
				onx_q  <= '0;
				onz_q  <= '0;
				ovn_q  <= '0;
				if (!k_q[0]) begin
					ota_q <= base + IDX_W'(3);
					otb_q <= base + IDX_W'(1);
					otc_q <= base;
				end else begin
					ota_q <= base;
					otb_q <= base + IDX_W'(2);
					otc_q <= base + IDX_W'(3);
				end
			end
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.kind          = kind_q;
	assign result_ch.pos_x         = opx_q;
	assign result_ch.pos_y         = opy_q;
	assign result_ch.pos_z         = opz_q;
	assign result_ch.norm_x        = onx_q;
	assign result_ch.norm_z        = onz_q;
	assign result_ch.vertex_number = ovn_q;
	assign result_ch.tri_a         = ota_q;
	assign result_ch.tri_b         = otb_q;
	assign result_ch.tri_c         = otc_q;
	assign result_ch.last          = olast_q;

	// checks
	assign rot_ok     = int'(it_q) < CORDIC_STEPS;
	assign norm_ok    = (c_q <= 16'sd16384) && (c_q >= -16'sd16384)
		&& (s_q <= 16'sd16384) && (s_q >= -16'sd16384);
	assign emit_stall = (state_q == ST_EMIT) && out_valid_q && !result_ch.ready;

	`CMG_ASSERT_SAME(a_rot_count, clk, arst_n, state_q == ST_ROT, rot_ok, "CORDIC step overrun")
	`CMG_ASSERT_NEXT(a_norm_clamp, clk, arst_n, state_q == ST_ROUND, norm_ok, "normal out of range")
	`CMG_ASSERT_NEXT(a_emit_hold, clk, arst_n, emit_stall, $stable({k_q, state_q}), "stall not held")
	`CMG_ASSERT_NEXT(a_skip_idle, clk, arst_n, accept && skip, state_q == ST_IDLE, "slice not dropped")

endmodule

`default_nettype wire
